// File: hw/rtl/qfpt_pkg.sv
// ----------------------------------------------------------------------------
// qfpt_pkg: shared types and constants for the frame point transform
// Item layouts for both channels, the queued command and fixed-point widths.
// ----------------------------------------------------------------------------
package qfpt_pkg;

    // Opcode values carried in the input item
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    // One input beat
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               clipped;
    } out_item_t;

    // Item class decided by the front end
    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_POINT = 1'b1
    } kind_t;

    // Queue entry between front and back
    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } cmd_t;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Datapath widths
    localparam int MUL_W   = 32;  // multiplier operand
    localparam int PROD_W  = 64;  // multiplier product
    localparam int QP_W    = 32;  // quaternion component product
    localparam int R_W     = 35;  // rotation entry, Q.28
    localparam int R_LO_W  = 17;  // low slice of a rotation entry
    localparam int ACC_W   = 66;  // row sum of three products
    localparam int SAT_W   = 67;  // wide value ahead of saturation

    // Rotation entries carry 28 fraction bits
    localparam int QUAT_SHIFT = 28;
    localparam logic signed [R_W-1:0]    ONE_Q28 = R_W'(1) << QUAT_SHIFT;
    localparam logic signed [PROD_W-1:0] LO_BIAS = PROD_W'(1) << (QUAT_SHIFT - 1);

    // 32-bit signed limits
    localparam logic signed [31:0]      Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]      Q_MIN   = 32'sh8000_0000;
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(Q_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(Q_MIN);

    // Saturated value with its flag
    typedef struct packed {
        logic               flag;
        logic signed [31:0] val;
    } sat_t;

endpackage

// File: hw/rtl/qfpt_front.sv
// ----------------------------------------------------------------------------
// qfpt_front: input acceptance and command queue
// Accepts input beats, tags each as a frame load or a point, and holds them
// in a short queue so the back end can stall without blocking the sender.
// ----------------------------------------------------------------------------
module qfpt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qfpt_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output qfpt_pkg::cmd_t     q_cmd
);

    qfpt_pkg::cmd_t cmd_mem [qfpt_pkg::QUEUE_DEPTH];

    logic [qfpt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [qfpt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [qfpt_pkg::QCNT_W-1:0] count_reg, count_next;
    qfpt_pkg::cmd_t              in_cmd;
    logic                        push;
    logic                        pop;

    // Classify the incoming beat
    always_comb begin
        in_cmd.item = s_data;
        in_cmd.kind = (s_data.opcode == qfpt_pkg::OP_POINT) ? qfpt_pkg::KIND_POINT
                                                             : qfpt_pkg::KIND_LOAD;
    end

    assign s_ready = (count_reg != qfpt_pkg::QCNT_W'(qfpt_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = cmd_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            if (wr_ptr_reg == qfpt_pkg::QPTR_W'(qfpt_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == qfpt_pkg::QPTR_W'(qfpt_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        count_next = count_reg + qfpt_pkg::QCNT_W'(push) - qfpt_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the beat
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: hw/rtl/qfpt_back.sv
// ----------------------------------------------------------------------------
// qfpt_back: frame build and point transform engine
// Three shared row multipliers, sequenced to build the scaled rotation matrix
// on a load and to form M*p + t on a point, with a registered result stage.
// ----------------------------------------------------------------------------
module qfpt_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  qfpt_pkg::cmd_t      q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output qfpt_pkg::out_item_t m_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_QMUL = 6'b000010,
        ST_RMAT = 6'b000100,
        ST_SMUL = 6'b001000,
        ST_PMUL = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Slots of the quaternion product table
    localparam int QP_XX = 0;
    localparam int QP_YY = 1;
    localparam int QP_ZZ = 2;
    localparam int QP_XY = 3;
    localparam int QP_XZ = 4;
    localparam int QP_YZ = 5;
    localparam int QP_WX = 6;
    localparam int QP_WY = 7;
    localparam int QP_WZ = 8;

    localparam logic signed [qfpt_pkg::ACC_W-1:0] ROUND_HALF =
        qfpt_pkg::ACC_W'(1) << (FRAC_BITS - 1);

    state_t                               state_reg, state_next;
    logic [2:0]                           step_reg, step_next;
    qfpt_pkg::in_item_t                   item_reg, item_next;
    logic signed [qfpt_pkg::PROD_W-1:0]   prod_reg [3];
    logic signed [qfpt_pkg::PROD_W-1:0]   prod_next [3];
    logic signed [qfpt_pkg::QP_W-1:0]     qp_reg [9];
    logic signed [qfpt_pkg::QP_W-1:0]     qp_next [9];
    logic signed [qfpt_pkg::R_W-1:0]      r_reg [9];
    logic signed [qfpt_pkg::R_W-1:0]      r_next [9];
    logic signed [qfpt_pkg::PROD_W-1:0]   lo_reg [3];
    logic signed [qfpt_pkg::PROD_W-1:0]   lo_next [3];
    logic signed [qfpt_pkg::ACC_W-1:0]    acc_reg [3];
    logic signed [qfpt_pkg::ACC_W-1:0]    acc_next [3];
    logic signed [31:0]                   mat_reg [9];
    logic signed [31:0]                   mat_next [9];
    logic signed [31:0]                   off_reg [3];
    logic signed [31:0]                   off_next [3];
    logic                                 mclip_reg, mclip_next;
    logic                                 clip_acc_reg, clip_acc_next;
    logic                                 out_valid_reg, out_valid_next;
    qfpt_pkg::out_item_t                  out_data_reg, out_data_next;

    logic signed [qfpt_pkg::MUL_W-1:0]    mul_a [3];
    logic signed [qfpt_pkg::MUL_W-1:0]    mul_b [3];
    logic [1:0]                           col;
    logic signed [qfpt_pkg::R_W-1:0]      col_r [3];
    logic signed [31:0]                   col_m [3];
    logic signed [31:0]                   col_v;
    logic signed [31:0]                   col_s;
    logic signed [qfpt_pkg::SAT_W-1:0]    ent_wide [3];
    qfpt_pkg::sat_t                       ent_sat [3];
    logic                                 ent_clip;
    logic signed [qfpt_pkg::SAT_W-1:0]    res_wide [3];
    qfpt_pkg::sat_t                       res_sat [3];
    logic                                 fire_out;

    function automatic qfpt_pkg::sat_t sat32(input logic signed [qfpt_pkg::SAT_W-1:0] v);
        qfpt_pkg::sat_t s;
        s.flag = 1'b0;
        s.val  = v[31:0];
        if (v > qfpt_pkg::SAT_MAX) begin
            s.flag = 1'b1;
            s.val  = qfpt_pkg::Q_MAX;
        end else if (v < qfpt_pkg::SAT_MIN) begin
            s.flag = 1'b1;
            s.val  = qfpt_pkg::Q_MIN;
        end
        return s;
    endfunction

    // Diagonal rotation entry: 1 - 2(a + b)
    function automatic logic signed [qfpt_pkg::R_W-1:0] r_diag(
        input logic signed [qfpt_pkg::QP_W-1:0] a,
        input logic signed [qfpt_pkg::QP_W-1:0] b
    );
        return qfpt_pkg::ONE_Q28 - ((qfpt_pkg::R_W'(a) + qfpt_pkg::R_W'(b)) <<< 1);
    endfunction

    // Off-diagonal rotation entry: 2(a + b) or 2(a - b)
    function automatic logic signed [qfpt_pkg::R_W-1:0] r_side(
        input logic signed [qfpt_pkg::QP_W-1:0] a,
        input logic signed [qfpt_pkg::QP_W-1:0] b,
        input logic                             neg
    );
        logic signed [qfpt_pkg::R_W-1:0] t;
        if (neg) begin
            t = qfpt_pkg::R_W'(a) - qfpt_pkg::R_W'(b);
        end else begin
            t = qfpt_pkg::R_W'(a) + qfpt_pkg::R_W'(b);
        end
        return t <<< 1;
    endfunction

    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign fire_out = !out_valid_reg || m_ready;

    // Pick the column worked on this step
    always_comb begin
        case (state_reg)
            ST_SMUL: col = step_reg[2:1];
            ST_PMUL: col = step_reg[1:0];
            default: col = 2'd3;
        endcase
        for (int i = 0; i < 3; i++) begin
            col_r[i] = '0;
            col_m[i] = '0;
        end
        col_v = '0;
        col_s = '0;
        case (col)
            2'd0: begin
                for (int i = 0; i < 3; i++) begin
                    col_r[i] = r_reg[3 * i];
                    col_m[i] = mat_reg[3 * i];
                end
                col_v = item_reg.vec_x;
                col_s = item_reg.scale_x;
            end
            2'd1: begin
                for (int i = 0; i < 3; i++) begin
                    col_r[i] = r_reg[3 * i + 1];
                    col_m[i] = mat_reg[3 * i + 1];
                end
                col_v = item_reg.vec_y;
                col_s = item_reg.scale_y;
            end
            2'd2: begin
                for (int i = 0; i < 3; i++) begin
                    col_r[i] = r_reg[3 * i + 2];
                    col_m[i] = mat_reg[3 * i + 2];
                end
                col_v = item_reg.vec_z;
                col_s = item_reg.scale_z;
            end
            default: begin
                col_v = '0;
            end
        endcase
    end

    // Multiplier operands
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (state_reg)
            ST_QMUL: begin
                case (step_reg)
                    3'd0: begin
                        mul_a[0] = qfpt_pkg::MUL_W'(item_reg.quat_x);
                        mul_b[0] = qfpt_pkg::MUL_W'(item_reg.quat_x);
                        mul_a[1] = qfpt_pkg::MUL_W'(item_reg.quat_y);
                        mul_b[1] = qfpt_pkg::MUL_W'(item_reg.quat_y);
                        mul_a[2] = qfpt_pkg::MUL_W'(item_reg.quat_z);
                        mul_b[2] = qfpt_pkg::MUL_W'(item_reg.quat_z);
                    end
                    3'd1: begin
                        mul_a[0] = qfpt_pkg::MUL_W'(item_reg.quat_x);
                        mul_b[0] = qfpt_pkg::MUL_W'(item_reg.quat_y);
                        mul_a[1] = qfpt_pkg::MUL_W'(item_reg.quat_x);
                        mul_b[1] = qfpt_pkg::MUL_W'(item_reg.quat_z);
                        mul_a[2] = qfpt_pkg::MUL_W'(item_reg.quat_y);
                        mul_b[2] = qfpt_pkg::MUL_W'(item_reg.quat_z);
                    end
                    3'd2: begin
                        mul_a[0] = qfpt_pkg::MUL_W'(item_reg.quat_w);
                        mul_b[0] = qfpt_pkg::MUL_W'(item_reg.quat_x);
                        mul_a[1] = qfpt_pkg::MUL_W'(item_reg.quat_w);
                        mul_b[1] = qfpt_pkg::MUL_W'(item_reg.quat_y);
                        mul_a[2] = qfpt_pkg::MUL_W'(item_reg.quat_w);
                        mul_b[2] = qfpt_pkg::MUL_W'(item_reg.quat_z);
                    end
                    default: begin
                        mul_a[0] = '0;
                    end
                endcase
            end
            ST_SMUL: begin
                // Low slice is unsigned, high slice carries the sign
                for (int i = 0; i < 3; i++) begin
                    if (step_reg[0]) begin
                        mul_a[i] = qfpt_pkg::MUL_W'(
                            $signed(col_r[i][qfpt_pkg::R_W-1:qfpt_pkg::R_LO_W]));
                    end else begin
                        mul_a[i] = $signed(qfpt_pkg::MUL_W'(col_r[i][qfpt_pkg::R_LO_W-1:0]));
                    end
                    mul_b[i] = col_s;
                end
            end
            ST_PMUL: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = col_m[i];
                    mul_b[i] = col_v;
                end
            end
            default: begin
                mul_a[0] = '0;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = mul_a[i] * mul_b[i];
        end
    end

    // Scaled matrix entries and point results ahead of saturation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ent_wide[i] = ((qfpt_pkg::SAT_W'(prod_reg[i]) <<< qfpt_pkg::R_LO_W)
                          + qfpt_pkg::SAT_W'(lo_reg[i])) >>> qfpt_pkg::QUAT_SHIFT;
            ent_sat[i]  = sat32(ent_wide[i]);
            res_wide[i] = qfpt_pkg::SAT_W'(acc_reg[i] >>> FRAC_BITS)
                        + qfpt_pkg::SAT_W'(off_reg[i]);
            res_sat[i]  = sat32(res_wide[i]);
        end
        ent_clip = ent_sat[0].flag || ent_sat[1].flag || ent_sat[2].flag;
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        qp_next        = qp_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        acc_next       = acc_reg;
        mat_next       = mat_reg;
        off_next       = off_reg;
        mclip_next     = mclip_reg;
        clip_acc_next  = clip_acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        q_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next  = q_cmd.item;
                    step_next  = '0;
                    state_next = (q_cmd.kind == qfpt_pkg::KIND_LOAD) ? ST_QMUL : ST_PMUL;
                end
            end
            ST_QMUL: begin
                // Capture the products issued one step earlier
                case (step_reg)
                    3'd1: begin
                        qp_next[QP_XX] = prod_reg[0][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_YY] = prod_reg[1][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_ZZ] = prod_reg[2][qfpt_pkg::QP_W-1:0];
                    end
                    3'd2: begin
                        qp_next[QP_XY] = prod_reg[0][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_XZ] = prod_reg[1][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_YZ] = prod_reg[2][qfpt_pkg::QP_W-1:0];
                    end
                    3'd3: begin
                        qp_next[QP_WX] = prod_reg[0][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_WY] = prod_reg[1][qfpt_pkg::QP_W-1:0];
                        qp_next[QP_WZ] = prod_reg[2][qfpt_pkg::QP_W-1:0];
                    end
                    default: begin
                        qp_next = qp_reg;
                    end
                endcase
                if (step_reg == 3'd3) begin
                    state_next = ST_RMAT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RMAT: begin
                // Form the unscaled rotation in Q.28
                r_next[0]     = r_diag(qp_reg[QP_YY], qp_reg[QP_ZZ]);
                r_next[1]     = r_side(qp_reg[QP_XY], qp_reg[QP_WZ], 1'b1);
                r_next[2]     = r_side(qp_reg[QP_XZ], qp_reg[QP_WY], 1'b0);
                r_next[3]     = r_side(qp_reg[QP_XY], qp_reg[QP_WZ], 1'b0);
                r_next[4]     = r_diag(qp_reg[QP_XX], qp_reg[QP_ZZ]);
                r_next[5]     = r_side(qp_reg[QP_YZ], qp_reg[QP_WX], 1'b1);
                r_next[6]     = r_side(qp_reg[QP_XZ], qp_reg[QP_WY], 1'b1);
                r_next[7]     = r_side(qp_reg[QP_YZ], qp_reg[QP_WX], 1'b0);
                r_next[8]     = r_diag(qp_reg[QP_XX], qp_reg[QP_YY]);
                clip_acc_next = 1'b0;
                step_next     = '0;
                state_next    = ST_SMUL;
            end
            ST_SMUL: begin
                if (step_reg[0]) begin
                    // Hold the low partial product with the rounding bias folded in
                    for (int i = 0; i < 3; i++) begin
                        lo_next[i] = prod_reg[i] + qfpt_pkg::LO_BIAS;
                    end
                end else if (step_reg != 3'd0) begin
                    // Combine high and low partials and write one column
                    case (step_reg[2:1])
                        2'd1: begin
                            for (int i = 0; i < 3; i++) begin
                                mat_next[3 * i] = ent_sat[i].val;
                            end
                        end
                        2'd2: begin
                            for (int i = 0; i < 3; i++) begin
                                mat_next[3 * i + 1] = ent_sat[i].val;
                            end
                        end
                        2'd3: begin
                            for (int i = 0; i < 3; i++) begin
                                mat_next[3 * i + 2] = ent_sat[i].val;
                            end
                        end
                        default: begin
                            mat_next = mat_reg;
                        end
                    endcase
                    clip_acc_next = clip_acc_reg || ent_clip;
                end
                if (step_reg == 3'd6) begin
                    off_next[0] = item_reg.vec_x;
                    off_next[1] = item_reg.vec_y;
                    off_next[2] = item_reg.vec_z;
                    mclip_next  = clip_acc_reg || ent_clip;
                    state_next  = ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_PMUL: begin
                // Start each row sum at the rounding bias, then add products
                for (int i = 0; i < 3; i++) begin
                    if (step_reg == 3'd0) begin
                        acc_next[i] = ROUND_HALF;
                    end else begin
                        acc_next[i] = acc_reg[i] + qfpt_pkg::ACC_W'(prod_reg[i]);
                    end
                end
                if (step_reg == 3'd3) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN: begin
                // Drop the result into the output register once it is free
                if (fire_out) begin
                    out_valid_next        = 1'b1;
                    out_data_next.pos_x   = res_sat[0].val;
                    out_data_next.pos_y   = res_sat[1].val;
                    out_data_next.pos_z   = res_sat[2].val;
                    out_data_next.clipped = mclip_reg || res_sat[0].flag
                                            || res_sat[1].flag || res_sat[2].flag;
                    q_ready               = 1'b1;
                    if (q_valid) begin
                        item_next  = q_cmd.item;
                        step_next  = '0;
                        state_next = (q_cmd.kind == qfpt_pkg::KIND_LOAD) ? ST_QMUL
                                                                          : ST_PMUL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            clip_acc_reg  <= 1'b0;
            mclip_reg     <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                mat_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            clip_acc_reg  <= clip_acc_next;
            mclip_reg     <= mclip_next;
            mat_reg       <= mat_next;
            off_reg       <= off_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        qp_reg       <= qp_next;
        r_reg        <= r_next;
        lo_reg       <= lo_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: hw/rtl/quaternion_frame_point_transform_top.sv
// ----------------------------------------------------------------------------
// quaternion_frame_point_transform_top: frame load and point transform
// A load beat sets a scaled rotation plus offset; point beats are mapped
// through it in Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item per beat. opcode OP_LOAD takes
//   translation, quaternion and scale and gives no result; OP_POINT takes a
//   point and gives one beat on m_valid/m_ready/m_data.
//   Items pass through a two-deep command queue into the engine, which runs
//   three row multipliers side by side. A point occupies the engine for four
//   multiply-accumulate steps and one round and saturate step, in which the
//   result goes to the output register and the next item may be taken, so
//   points follow without a gap while the receiver keeps up. A load occupies
//   the engine for four quaternion product steps, one rotation build step,
//   six scaled partial products and a final combine, then the engine goes
//   back to idle, where it takes the next item.
//   Reset clears the frame to all zero and empties the queue and output.
//   When the receiver stalls, the result is held in the output register,
//   the engine waits in its final step and the queue fills; s_ready falls
//   once the queue is full.
// ----------------------------------------------------------------------------
module quaternion_frame_point_transform_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qfpt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qfpt_pkg::out_item_t m_data
);

    logic           q_valid;
    logic           q_ready;
    qfpt_pkg::cmd_t q_cmd;

    qfpt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    qfpt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hw/rtl/qfpt_checker.sv
// ----------------------------------------------------------------------------
// qfpt_checker: port-level checks for the frame point transform
// Tracks points in flight and checks result beats against them.
// ----------------------------------------------------------------------------
module qfpt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input qfpt_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input qfpt_pkg::out_item_t m_data
);

    logic [2:0] pending_reg, pending_next;
    logic       pt_in;
    logic       pt_out;

    // Count points taken but not yet delivered
    assign pt_in  = s_valid && s_ready && (s_data.opcode == qfpt_pkg::OP_POINT);
    assign pt_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg + 3'(pt_in) - 3'(pt_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat stays up
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result beat keeps its payload
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // Every result belongs to a point taken earlier
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without a pending point");

    // Queue, engine and output register hold at most four points
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd4)
        else $error("too many points in flight");

endmodule

bind quaternion_frame_point_transform_top qfpt_checker u_qfpt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: dv/qfpt_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qfpt_sb_pkg: frame transform scoreboard
// Holds a bit-exact copy of the stored frame, predicts each point beat's
// transformed position and checks returned beats against it in order.
// ----------------------------------------------------------------------------
package qfpt_sb_pkg;
    import qfpt_pkg::*;

    localparam int POINT_FRAC = 16;

    // Wide working values, with room for the unrounded products
    localparam logic signed [79:0] WIDE_MAX = Q_MAX;
    localparam logic signed [79:0] WIDE_MIN = Q_MIN;
    localparam logic signed [79:0] HALF_Q28 = 80'sd1 <<< (QUAT_SHIFT - 1);
    localparam logic signed [79:0] HALF_PT  = 80'sd1 <<< (POINT_FRAC - 1);

    // Clamp to 32 bits signed and say whether it clamped
    function automatic sat_t clamp32(input logic signed [79:0] v);
        sat_t r;
        r.flag = 1'b0;
        r.val  = v[31:0];
        if (v > WIDE_MAX) begin
            r.flag = 1'b1;
            r.val  = Q_MAX;
        end else if (v < WIDE_MIN) begin
            r.flag = 1'b1;
            r.val  = Q_MIN;
        end
        return r;
    endfunction

    class frame_scoreboard;
        logic signed [31:0] frame_mat [9];
        logic signed [31:0] frame_off [3];
        bit                 frame_clip;
        out_item_t          expected_pos_q [$];
        int                 n_loads;
        int                 n_points;
        int                 n_checked;
        int                 n_clip_flags;
        int                 n_faults;

        function new();
            foreach (frame_mat[i]) frame_mat[i] = '0;
            foreach (frame_off[i]) frame_off[i] = '0;
            frame_clip   = 1'b0;
            n_loads      = 0;
            n_points     = 0;
            n_checked    = 0;
            n_clip_flags = 0;
            n_faults     = 0;
        endfunction

        function void note_fault(string msg);
            n_faults++;
            if (n_faults <= 10) $display("%s", msg);
        endfunction

        // Build R(q) in Q.28, scale each column and round to the frame format
        function void load_frame(in_item_t it);
            logic signed [79:0] qx, qy, qz, qw;
            logic signed [79:0] rot [9];
            logic signed [79:0] scl [3];
            logic signed [79:0] prod;
            sat_t               s;
            bit                 clip;
            qx = $signed(it.quat_x);
            qy = $signed(it.quat_y);
            qz = $signed(it.quat_z);
            qw = $signed(it.quat_w);
            scl[0] = $signed(it.scale_x);
            scl[1] = $signed(it.scale_y);
            scl[2] = $signed(it.scale_z);
            rot[0] = ONE_Q28 - 2 * (qy * qy + qz * qz);
            rot[1] = 2 * (qx * qy - qw * qz);
            rot[2] = 2 * (qx * qz + qw * qy);
            rot[3] = 2 * (qx * qy + qw * qz);
            rot[4] = ONE_Q28 - 2 * (qx * qx + qz * qz);
            rot[5] = 2 * (qy * qz - qw * qx);
            rot[6] = 2 * (qx * qz - qw * qy);
            rot[7] = 2 * (qy * qz + qw * qx);
            rot[8] = ONE_Q28 - 2 * (qx * qx + qy * qy);
            clip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod = rot[3 * i + j] * scl[j];
                    s    = clamp32((prod + HALF_Q28) >>> QUAT_SHIFT);
                    frame_mat[3 * i + j] = s.val;
                    clip |= s.flag;
                end
            end
            frame_off[0] = it.vec_x;
            frame_off[1] = it.vec_y;
            frame_off[2] = it.vec_z;
            frame_clip   = clip;
            n_loads++;
        endfunction

        // Exact row sums, one rounding, then offset and clamp
        function void map_point(in_item_t it);
            logic signed [31:0] pt [3];
            logic signed [31:0] pos [3];
            logic signed [79:0] acc;
            sat_t               s;
            bit                 clip;
            out_item_t          e;
            pt[0] = it.vec_x;
            pt[1] = it.vec_y;
            pt[2] = it.vec_z;
            clip  = frame_clip;
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int j = 0; j < 3; j++) acc = acc + frame_mat[3 * i + j] * pt[j];
                acc = ((acc + HALF_PT) >>> POINT_FRAC) + frame_off[i];
                s = clamp32(acc);
                pos[i] = s.val;
                clip |= s.flag;
            end
            e.pos_x   = pos[0];
            e.pos_y   = pos[1];
            e.pos_z   = pos[2];
            e.clipped = clip;
            if (clip) n_clip_flags++;
            expected_pos_q = {expected_pos_q, e};
            n_points++;
        endfunction

        // Accepted input beat
        function void take_item(in_item_t it);
            if (it.opcode == OP_LOAD) load_frame(it);
            else map_point(it);
        endfunction

        // Accepted result beat against the oldest expected position
        function void check_position(out_item_t got);
            out_item_t e;
            bit        bad;
            if (expected_pos_q.size() == 0) begin
                note_fault($sformatf("unexpected result beat: pos %0d %0d %0d clipped %0d",
                                     got.pos_x, got.pos_y, got.pos_z, got.clipped));
                return;
            end
            e = expected_pos_q.pop_front();
            n_checked++;
            bad = 1'b0;
            if (got.pos_x !== e.pos_x) bad = 1'b1;
            if (got.pos_y !== e.pos_y) bad = 1'b1;
            if (got.pos_z !== e.pos_z) bad = 1'b1;
            if (got.clipped !== e.clipped) bad = 1'b1;
            if (bad) begin
                note_fault($sformatf(
                    "mismatch on result %0d: expected %0d %0d %0d clip %0d, got %0d %0d %0d clip %0d",
                    n_checked, e.pos_x, e.pos_y, e.pos_z, e.clipped,
                    got.pos_x, got.pos_y, got.pos_z, got.clipped));
            end
        endfunction

        function int pending();
            return expected_pos_q.size();
        endfunction

        function void close_out();
            if (expected_pos_q.size() != 0)
                note_fault($sformatf("%0d expected results never arrived",
                                     expected_pos_q.size()));
        endfunction
    endclass

endpackage

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: quaternion frame point transform testbench
// Drives frame loads and point beats with random gaps, stalls the result
// channel at random and checks every result against a bit-exact prediction.
// ----------------------------------------------------------------------------
module tb;
    import qfpt_pkg::*;
    import qfpt_sb_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 950;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    bit          calm        = 1'b0;
    int          quiet_count = 0;
    frame_scoreboard sb = new();

    quaternion_frame_point_transform_top #(
        .FRAC_BITS(POINT_FRAC)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel at random, except in the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 32);
    end

    // Check results first, then note inputs, on every accepted beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_position(m_data);
            if (s_valid && s_ready) sb.take_item(s_data);
        end
    end

    // Watchdog: give up after a long run of cycles with no beat moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic in_item_t load_item(
        input logic signed [31:0] tx, ty, tz,
        input logic signed [15:0] qx, qy, qz, qw,
        input logic signed [31:0] sx, sy, sz
    );
        in_item_t it;
        it.opcode  = OP_LOAD;
        it.vec_x   = tx;
        it.vec_y   = ty;
        it.vec_z   = tz;
        it.quat_x  = qx;
        it.quat_y  = qy;
        it.quat_z  = qz;
        it.quat_w  = qw;
        it.scale_x = sx;
        it.scale_y = sy;
        it.scale_z = sz;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sh0000_8000;
                endcase
            end
            2, 3: return int'($urandom_range(1048576)) - 524288;
            default: return int'($urandom_range(33554432)) - 16777216;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(9))
            0, 1: return 16'($urandom);
            2: begin
                case ($urandom_range(5))
                    0: return 16'sd16384;
                    1: return -16'sd16384;
                    2: return 16'sd0;
                    3: return 16'sd8192;
                    4: return 16'sh8000;
                    default: return 16'sh7FFF;
                endcase
            end
            default: return 16'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return 32'sd0;
                    1: return Q_MAX;
                    2: return Q_MIN;
                    3: return -32'sd65536;
                    default: return 32'sd65536;
                endcase
            end
            default: return int'($urandom_range(262144)) - 65536;
        endcase
    endfunction

    function automatic in_item_t make_load();
        in_item_t it;
        it = load_item(rand_coord(), rand_coord(), rand_coord(),
                       rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                       rand_scale(), rand_scale(), rand_scale());
        // Sometimes use a unit quaternion so results stay in range
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
                0: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
                1: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
                2: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd0, 16'sd16384, 16'sd0, 16'sd0};
                3: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd0, 16'sd0, 16'sd16384, 16'sd0};
                4: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
                default: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {16'sd0, 16'sd0, 16'sd11585, 16'sd11585};
            endcase
        end
        return it;
    endfunction

    // Point beats carry random bits in the fields the block ignores
    function automatic in_item_t make_point(input logic signed [31:0] x, y, z);
        in_item_t it;
        it = load_item(x, y, z, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom, $urandom, $urandom);
        it.opcode = OP_POINT;
        return it;
    endfunction

    // Send one beat: optional idle gap, then hold valid until taken
    task automatic send_beat(input in_item_t it);
        while (!calm && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            s_data  <= make_load();
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_directed();
        // Point before any frame: all zero, no clipping
        send_beat(make_point(Q_MAX, Q_MIN, 32'sd12345));
        // Identity frame with an offset, then in-range and saturating points
        send_beat(load_item(32'sd196608, -32'sd65536, 32'sd0,
                            16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                            32'sd65536, 32'sd65536, 32'sd65536));
        send_beat(make_point(32'sd65536, 32'sd131072, -32'sd65536));
        send_beat(make_point(Q_MAX, Q_MIN, 32'sd0));
        // Matrix rounding ties: entries land exactly half way
        send_beat(load_item(32'sd0, 32'sd0, 32'sd0,
                            16'sd1, 16'sd0, 16'sd0, 16'sd0,
                            32'sd67108864, -32'sd67108864, 32'sd201326592));
        send_beat(make_point(32'sd65536, 32'sd65536, 32'sd65536));
        // Point rounding ties: diagonal of one least significant bit
        send_beat(load_item(32'sd0, 32'sd0, 32'sd0,
                            16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                            32'sd1, 32'sd1, 32'sd1));
        send_beat(make_point(32'sd32768, -32'sd32768, 32'sd98304));
        send_beat(make_point(-32'sd1, 32'sd1, 32'sd0));
        // Most negative quaternion and extreme scales: matrix saturates
        send_beat(load_item(Q_MIN, Q_MAX, -32'sd1,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            Q_MAX, Q_MIN, Q_MAX));
        send_beat(make_point(32'sd0, 32'sd0, 32'sd0));
        send_beat(make_point(Q_MIN, Q_MIN, Q_MIN));
        // Quaternion of norm two, used without normalising
        send_beat(load_item(Q_MAX, Q_MAX, Q_MAX,
                            16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                            32'sd65536, 32'sd65536, 32'sd65536));
        send_beat(make_point(32'sd65536, 32'sd0, 32'sd0));
        send_beat(make_point(Q_MAX, Q_MAX, Q_MAX));
        // Largest positive component, negative scales
        send_beat(load_item(32'sd1, -32'sd1, 32'sd0,
                            16'sh7FFF, 16'sd0, 16'sd0, 16'sd0,
                            -32'sd65536, Q_MIN, -32'sd1));
        send_beat(make_point(32'sd65536, -32'sd65536, Q_MAX));
        // Quarter turn about z with double scale
        send_beat(load_item(32'sd0, 32'sd0, 32'sd0,
                            16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
                            32'sd131072, 32'sd131072, 32'sd131072));
        send_beat(make_point(32'sd65536, 32'sd0, -32'sd65536));
        // Two loads back to back: the second one wins
        send_beat(load_item(32'sd1, 32'sd2, 32'sd3,
                            16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                            32'sd0, 32'sd0, 32'sd0));
        send_beat(load_item(-32'sd65536, 32'sd65536, 32'sd7,
                            16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192,
                            32'sd65536, -32'sd65536, 32'sd32768));
        send_beat(make_point(32'sd65536, 32'sd65536, 32'sd65536));
    endtask

    // Mostly frame loads followed by point runs; some stray points and reloads
    task automatic run_random();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm <= (sent >= 350 && sent < 600);
            case ($urandom_range(9))
                0: begin
                    send_beat(make_load());
                    send_beat(make_load());
                    sent += 2;
                end
                1: begin
                    send_beat(make_point(rand_coord(), rand_coord(), rand_coord()));
                    sent++;
                end
                default: begin
                    run_len = $urandom_range(15, 1);
                    send_beat(make_load());
                    for (int i = 0; i < run_len; i++)
                        send_beat(make_point(rand_coord(), rand_coord(), rand_coord()));
                    sent += run_len + 1;
                end
            endcase
        end
        calm <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();
        $display("covered %0d frame loads and %0d point beats, %0d results checked",
                 sb.n_loads, sb.n_points, sb.n_checked);
        $display("%0d results carried the saturation flag, %0d faults found",
                 sb.n_clip_flags, sb.n_faults);
        if (sb.n_faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
